// ----- rtl/skrq_pkg.sv -----
// Package with the shared constants and codes of the sorted key range query block.
`timescale 1ns / 1ps
package skrq_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int INDEX_WIDTH = 16;
    localparam int KEY_W       = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = KEY_W + INDEX_WIDTH;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 16;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_MATCH    = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;
endpackage

// ----- rtl/skrq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module skrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/sorted_key_range_query.sv -----
// Top level of the sorted key range query block: sequencer, table memory and result register.
`timescale 1ns / 1ps
// The block holds up to 64 (key, index) pairs in key order in one table memory with a single
// read port. Unless the table is full, an add shifts each entry that sorts after the new one up
// by one place and writes the new pair into the gap. A query scans the stored entries once per
// distinct matching index, then hands over one transfer per copy of that index; matches come
// out in ascending index order and the final one carries tlast. Every item ends in at least one
// transfer, and the input is not ready until its last transfer is in the result register.
module sorted_key_range_query (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_low [31:0], key_high [63:32], entry_index [79:64]
    input  logic [skrq_pkg::IN_DATA_W-1:0]  s_tdata,
    // func [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found_index [15:0]
    output logic [skrq_pkg::OUT_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [2:0]                         state_reg, state_next;
    logic [skrq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [skrq_pkg::CNT_W-1:0]         ptr_reg, ptr_next;
    logic [skrq_pkg::KEY_W-1:0]         klo_reg, klo_next, khi_reg, khi_next;
    logic [skrq_pkg::INDEX_WIDTH-1:0]   nidx_reg, nidx_next;
    logic                               have_prev_reg, have_prev_next;
    logic [skrq_pkg::INDEX_WIDTH-1:0]   prev_reg, prev_next, min_reg, min_next;
    logic [skrq_pkg::CNT_W-1:0]         mult_reg, mult_next;
    logic [skrq_pkg::CNT_W-1:0]         total_reg, total_next, done_reg, done_next;
    logic                               rd_vld_reg, rd_vld_next;
    logic [1:0]                         resp_reg, resp_next;
    logic                               mv_reg, mv_next, ml_reg, ml_next;
    logic [1:0]                         ms_reg, ms_next;
    logic [skrq_pkg::INDEX_WIDTH-1:0]   mi_reg, mi_next;

    logic                               we;
    logic [skrq_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [skrq_pkg::ENTRY_W-1:0]       wdata, rdata;
    logic [skrq_pkg::KEY_W-1:0]         rkey;
    logic [skrq_pkg::INDEX_WIDTH-1:0]   ridx;
    logic                               out_free, in_acc, hit, after;

    function automatic logic [skrq_pkg::OUT_DATA_W-1:0] OUT_PAD(
        input logic [skrq_pkg::INDEX_WIDTH-1:0] v
    );
        return skrq_pkg::OUT_DATA_W'(v);
    endfunction

    skrq_ram #(.WIDTH(skrq_pkg::ENTRY_W), .DEPTH(skrq_pkg::TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rkey     = rdata[skrq_pkg::ENTRY_W-1:skrq_pkg::INDEX_WIDTH];
    assign ridx     = rdata[skrq_pkg::INDEX_WIDTH-1:0];
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign hit      = (rkey >= klo_reg) && (rkey <= khi_reg) && (!have_prev_reg || ridx > prev_reg);
    assign after    = (rkey > klo_reg) || ((rkey == klo_reg) && (ridx > nidx_reg));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        klo_next       = klo_reg;
        khi_next       = khi_reg;
        nidx_next      = nidx_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        min_next       = min_reg;
        mult_next      = mult_reg;
        total_next     = total_reg;
        done_next      = done_reg;
        rd_vld_next    = 1'b0;
        resp_next      = resp_reg;
        mv_next        = mv_reg && !m_tready;
        ms_next        = ms_reg;
        mi_next        = mi_reg;
        ml_next        = ml_reg;
        we             = 1'b0;
        waddr          = ptr_reg[skrq_pkg::ADDR_W-1:0];
        wdata          = {klo_reg, nidx_reg};
        raddr          = ptr_reg[skrq_pkg::ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    klo_next       = s_tdata[31:0];
                    khi_next       = s_tdata[63:32];
                    nidx_next      = s_tdata[64 +: skrq_pkg::INDEX_WIDTH];
                    ptr_next       = '0;
                    have_prev_next = 1'b0;
                    mult_next      = '0;
                    total_next     = '0;
                    done_next      = '0;
                    if (s_tuser == skrq_pkg::FUNC_ADD) begin
                        if (count_reg == skrq_pkg::CNT_W'(skrq_pkg::TABLE_DEPTH)) begin
                            resp_next  = skrq_pkg::ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            ptr_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end else if (count_reg == '0) begin
                        resp_next  = skrq_pkg::ST_NO_MATCH;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_INS_RD: begin
                raddr = ptr_reg[skrq_pkg::ADDR_W-1:0] - 1'b1;
                if (ptr_reg == '0) begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    resp_next  = skrq_pkg::ST_ADDED;
                    state_next = S_RESP;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                we = 1'b1;
                if (after) begin
                    wdata      = rdata;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    resp_next  = skrq_pkg::ST_ADDED;
                    state_next = S_RESP;
                end
            end
            S_SCAN: begin
                if (ptr_reg != count_reg) begin
                    rd_vld_next = 1'b1;
                    ptr_next    = ptr_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (hit) begin
                        if (!have_prev_reg) begin
                            total_next = total_reg + 1'b1;
                        end
                        if (mult_reg == '0 || ridx < min_reg) begin
                            min_next  = ridx;
                            mult_next = skrq_pkg::CNT_W'(1);
                        end else if (ridx == min_reg) begin
                            mult_next = mult_reg + 1'b1;
                        end
                    end
                end else if (ptr_reg == count_reg) begin
                    if (mult_reg == '0) begin
                        resp_next  = skrq_pkg::ST_NO_MATCH;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    ms_next   = skrq_pkg::ST_MATCH;
                    mi_next   = min_reg;
                    ml_next   = (done_reg + 1'b1 == total_reg);
                    done_next = done_reg + 1'b1;
                    mult_next = mult_reg - 1'b1;
                    if (done_reg + 1'b1 == total_reg) begin
                        state_next = S_IDLE;
                    end else if (mult_reg == skrq_pkg::CNT_W'(1)) begin
                        have_prev_next = 1'b1;
                        prev_next      = min_reg;
                        ptr_next       = '0;
                        mult_next      = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    ms_next    = resp_reg;
                    mi_next    = '0;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mv_reg     <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mv_reg     <= mv_next;
            rd_vld_reg <= rd_vld_next;
        end
        ptr_reg       <= ptr_next;
        klo_reg       <= klo_next;
        khi_reg       <= khi_next;
        nidx_reg      <= nidx_next;
        have_prev_reg <= have_prev_next;
        prev_reg      <= prev_next;
        min_reg       <= min_next;
        mult_reg      <= mult_next;
        total_reg     <= total_next;
        done_reg      <= done_next;
        resp_reg      <= resp_next;
        ms_reg        <= ms_next;
        mi_reg        <= mi_next;
        ml_reg        <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = ms_reg;
    assign m_tdata  = OUT_PAD(mi_reg);
    assign m_tlast  = ml_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= skrq_pkg::CNT_W'(skrq_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_notlast_is_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == skrq_pkg::ST_MATCH))
        else $error("non-final transfer that is not a match");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after an accepted item");
endmodule

// ----- test/tb.sv -----
// Testbench for the sorted key range query block: random and directed adds and range queries.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_index;
        logic        last;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [31:0] table_keys [skrq_pkg::TABLE_DEPTH];
    logic [15:0] table_idx [skrq_pkg::TABLE_DEPTH];
    int          table_count;
    answer_t     answers_due [$];
    int          fail_count;
    int          items_sent;
    int          answers_seen;
    bit          no_stall;

    sorted_key_range_query i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("Mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Works out the answers of one item and keeps the table up to date.
    task automatic predict_table(input logic func, input logic [31:0] klo,
                                 input logic [31:0] khi, input logic [15:0] idx);
        logic [15:0] hits [$];
        answer_t     a;
        int          i;
        if (func == skrq_pkg::FUNC_ADD) begin
            if (table_count >= skrq_pkg::TABLE_DEPTH) begin
                a = '{skrq_pkg::ST_FULL, 16'd0, 1'b1};
            end else begin
                i = table_count;
                while (i > 0 && (table_keys[i-1] > klo ||
                       (table_keys[i-1] == klo && table_idx[i-1] > idx))) begin
                    table_keys[i] = table_keys[i-1];
                    table_idx[i]  = table_idx[i-1];
                    i--;
                end
                table_keys[i] = klo;
                table_idx[i]  = idx;
                table_count++;
                a = '{skrq_pkg::ST_ADDED, 16'd0, 1'b1};
            end
            answers_due = {answers_due, a};
        end else begin
            for (i = 0; i < table_count; i++)
                if (table_keys[i] >= klo && table_keys[i] <= khi)
                    hits = {hits, table_idx[i]};
            hits.sort();
            if (hits.size() == 0) begin
                a = '{skrq_pkg::ST_NO_MATCH, 16'd0, 1'b1};
                answers_due = {answers_due, a};
            end else begin
                for (i = 0; i < hits.size(); i++) begin
                    a = '{skrq_pkg::ST_MATCH, hits[i], i == hits.size() - 1};
                    answers_due = {answers_due, a};
                end
            end
        end
    endtask

    task automatic send_item(input logic func, input logic [31:0] klo,
                             input logic [31:0] khi, input logic [15:0] idx);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {idx, khi, klo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_table(func, klo, khi, idx);
        items_sent++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        answer_t w;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                report("unexpected transfer status", m_tuser, 0);
            end else begin
                w = answers_due.pop_front();
                if (m_tuser !== w.status) report("status", m_tuser, w.status);
                if (m_tdata !== w.found_index) report("found_index", m_tdata, w.found_index);
                if (m_tlast !== w.last) report("last", m_tlast, w.last);
            end
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = no_stall ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic test_empty_table();
        send_item(skrq_pkg::FUNC_QUERY, 32'd0, 32'hFFFF_FFFF, 16'd0);
    endtask

    task automatic test_bounds_and_duplicates();
        send_item(skrq_pkg::FUNC_ADD, 32'd100, 32'd0, 16'd7);
        send_item(skrq_pkg::FUNC_ADD, 32'd100, 32'd0, 16'd3);
        send_item(skrq_pkg::FUNC_ADD, 32'd100, 32'd0, 16'd7);
        send_item(skrq_pkg::FUNC_ADD, 32'd101, 32'd0, 16'd1);
        send_item(skrq_pkg::FUNC_ADD, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(skrq_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'd100, 32'd100, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'd99, 32'd100, 16'hFFFF);
        send_item(skrq_pkg::FUNC_QUERY, 32'd101, 32'd100, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'd0, 32'd0, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'd0, 32'hFFFF_FFFF, 16'd0);
        send_item(skrq_pkg::FUNC_QUERY, 32'd102, 32'hFFFF_FFFE, 16'd0);
    endtask

    task automatic test_random_mix(input int count);
        logic [31:0] a, b;
        logic [15:0] idx;
        for (int n = 0; n < count; n++) begin
            no_stall = (n % 50) < 8;
            a = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
            b = ($urandom_range(0, 3) == 0) ? $urandom : a + $urandom_range(0, 150);
            if ($urandom_range(0, 9) == 0) b = $urandom;
            idx = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
            if ($urandom_range(0, 1) == 0 && table_count < skrq_pkg::TABLE_DEPTH)
                send_item(skrq_pkg::FUNC_ADD, a, $urandom, idx);
            else
                send_item(skrq_pkg::FUNC_QUERY, a, b, idx);
        end
        no_stall = 1'b0;
    endtask

    task automatic test_full_table();
        while (table_count < skrq_pkg::TABLE_DEPTH)
            send_item(skrq_pkg::FUNC_ADD, $urandom_range(0, 300), 32'd0, 16'($urandom));
        send_item(skrq_pkg::FUNC_ADD, 32'd5, 32'd0, 16'd5);
        send_item(skrq_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
        send_item(skrq_pkg::FUNC_QUERY, 32'd0, 32'hFFFF_FFFF, 16'd0);
        for (int n = 0; n < 20; n++)
            send_item(($urandom_range(0, 3) == 0) ? skrq_pkg::FUNC_ADD : skrq_pkg::FUNC_QUERY,
                      $urandom_range(0, 300), $urandom_range(0, 300), 16'($urandom));
    endtask

    initial begin
        int wait_cycles;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        no_stall   = 1'b0;
        table_count = 0;
        fail_count = 0;
        items_sent = 0;
        answers_seen = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_empty_table();
        test_bounds_and_duplicates();
        test_random_mix(170);
        test_full_table();
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (answers_due.size() != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (300) @(posedge aclk);
        $display("Sent %0d adds and queries, checked %0d result transfers,", items_sent,
                 answers_seen);
        $display("including an empty table, duplicate keys, inclusive bounds and a full table.");
        if (fail_count == 0 && answers_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/skrq_pkg.sv
rtl/skrq_ram.sv
rtl/sorted_key_range_query.sv
test/tb.sv
